[design/lrfg_pkg.sv]
// Package of the LED ramped flash generator.
// Holds field widths, register indexes, reset values, segment codes and the config struct.
// Depends on nothing; every other design file uses it.
package lrfg_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int DUTY_W      = 15;
    localparam int LEN_W       = 16;
    localparam int PCT_W       = 7;
    localparam int OFS_W       = 10;
    localparam int PERIOD_W    = LEN_W + 1;
    localparam int NUM_W       = LEN_W + DUTY_W;
    localparam int SCALED_W    = DUTY_W + PCT_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int PCT_MAX        = 100;
    localparam int DIV100_SHIFT   = SCALED_W;
    localparam int DIV100_RECIP_W = 16;
    localparam logic [DIV100_RECIP_W-1:0] DIV100_RECIP =
        DIV100_RECIP_W'((1 << DIV100_SHIFT) / PCT_MAX);

    localparam logic [CFG_INDEX_W-1:0] REG_ON_LENGTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_LENGTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INTENSITY   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_SCALE  = 3'd5;

    localparam logic [PCT_W-1:0]  INTENSITY_RESET  = 7'd100;
    localparam logic [DUTY_W-1:0] FULL_SCALE_RESET = 15'h7FFF;

    typedef logic [1:0] seg_t;
    localparam seg_t SEG_RISE = 2'd0;
    localparam seg_t SEG_TOP  = 2'd1;
    localparam seg_t SEG_FALL = 2'd2;
    localparam seg_t SEG_DARK = 2'd3;

    typedef struct packed {
        logic [LEN_W-1:0]  on_length;
        logic [LEN_W-1:0]  off_length;
        logic [LEN_W-1:0]  ramp_length;
        logic [PCT_W-1:0]  brightness_pct;
        logic [OFS_W-1:0]  phase_offset;
        logic [DUTY_W-1:0] full_scale;
    } cfg_t;

endpackage

[design/lrfg_if.sv]
// Stream interfaces of the LED ramped flash generator: sample indexes in, duty values out.
// Depends on lrfg_pkg for the payload widths.
interface lrfg_sample_if;
    logic                          valid;
    logic                          ready;
    logic [lrfg_pkg::SAMPLE_W-1:0] sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink (input valid, input sample_index, output ready);
endinterface

interface lrfg_duty_if;
    logic                        valid;
    logic                        ready;
    logic [lrfg_pkg::DUTY_W-1:0] duty;

    modport source (output valid, output duty, input ready);
    modport sink (input valid, input duty, output ready);
endinterface

[design/lrfg_position.sv]
// Three-stage front end: reduces the sample index and the offset modulo the buffer size
// and forms the shifted buffer position. Depends on lrfg_pkg.
module lrfg_position #(
    parameter int BUFFER_SAMPLES = 1024
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [lrfg_pkg::SAMPLE_W-1:0]           sample_index,
    input  logic [lrfg_pkg::OFS_W-1:0]              phase_offset,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [$clog2(BUFFER_SAMPLES)-1:0]       pos
);
    import lrfg_pkg::*;

    localparam int POS_W       = $clog2(BUFFER_SAMPLES);
    localparam int BUF_W       = $clog2(BUFFER_SAMPLES + 1);
    localparam int CW          = (BUF_W > SAMPLE_W) ? BUF_W : SAMPLE_W;
    localparam int RECIP_SHIFT = 2 * SAMPLE_W;
    localparam int PROD_W      = SAMPLE_W + RECIP_SHIFT;
    localparam logic [RECIP_SHIFT-1:0] RECIP =
        RECIP_SHIFT'((1 << RECIP_SHIFT) / BUFFER_SAMPLES);

    logic en1, en2, en3;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    logic [SAMPLE_W-1:0] s1_idx_reg, s1_ofs_reg, s1_qidx_reg, s1_qofs_reg;
    logic [SAMPLE_W-1:0] s2_ridx_reg, s2_rofs_reg;
    logic [POS_W-1:0]    s3_pos_reg;

    logic [PROD_W-1:0]   prod_idx, prod_ofs;
    logic [SAMPLE_W-1:0] s2_ridx_next, s2_rofs_next;
    logic [CW-1:0]       idx_fix, ofs_fix;
    logic [POS_W-1:0]    idx_mod, ofs_mod;
    logic [POS_W:0]      wrap_sum;
    logic [POS_W-1:0]    s3_pos_next;

    assign en3      = !s3_valid_reg || out_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    assign prod_idx = sample_index * RECIP;
    assign prod_ofs = phase_offset * RECIP;

    always_comb
    begin
        s2_ridx_next = s1_idx_reg - SAMPLE_W'(s1_qidx_reg * BUFFER_SAMPLES);
        s2_rofs_next = s1_ofs_reg - SAMPLE_W'(s1_qofs_reg * BUFFER_SAMPLES);
    end

    always_comb
    begin
        idx_fix = CW'(s2_ridx_reg);
        ofs_fix = CW'(s2_rofs_reg);
        if (idx_fix >= CW'(BUFFER_SAMPLES))
        begin
            idx_fix = idx_fix - CW'(BUFFER_SAMPLES);
        end
        if (ofs_fix >= CW'(BUFFER_SAMPLES))
        begin
            ofs_fix = ofs_fix - CW'(BUFFER_SAMPLES);
        end
        idx_mod  = POS_W'(idx_fix);
        ofs_mod  = POS_W'(ofs_fix);
        wrap_sum = {1'b0, idx_mod} + (POS_W + 1)'(BUFFER_SAMPLES) - {1'b0, ofs_mod};
        if (idx_mod >= ofs_mod)
        begin
            s3_pos_next = idx_mod - ofs_mod;
        end
        else
        begin
            s3_pos_next = POS_W'(wrap_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_idx_reg  <= sample_index;
            s1_ofs_reg  <= phase_offset;
            s1_qidx_reg <= prod_idx[PROD_W-1 -: SAMPLE_W];
            s1_qofs_reg <= prod_ofs[PROD_W-1 -: SAMPLE_W];
        end
        if (en2)
        begin
            s2_ridx_reg <= s2_ridx_next;
            s2_rofs_reg <= s2_rofs_next;
        end
        if (en3)
        begin
            s3_pos_reg <= s3_pos_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign pos       = s3_pos_reg;

endmodule

[design/lrfg_divider.sv]
// Pipelined restoring divider that retires STEP_BITS quotient bits per stage,
// with a sideband word that travels alongside. Depends on lrfg_pkg only by convention.
module lrfg_divider #(
    parameter int NUM_W     = 31,
    parameter int DEN_W     = 16,
    parameter int STEP_BITS = 4,
    parameter int SIDE_W    = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NUM_W-1:0]  quo,
    output logic [DEN_W-1:0]  rem,
    output logic [SIDE_W-1:0] side_out
);
    import lrfg_pkg::*;

    localparam int STAGES = (NUM_W + STEP_BITS - 1) / STEP_BITS;
    localparam int WORK_W = STAGES * STEP_BITS;

    logic [STAGES:0]   en;
    logic              valid_reg [STAGES];
    logic [DEN_W-1:0]  rem_reg   [STAGES];
    logic [WORK_W-1:0] quo_reg   [STAGES];
    logic [SIDE_W-1:0] side_reg  [STAGES];

    logic              valid_src [STAGES];
    logic [DEN_W-1:0]  rem_src   [STAGES];
    logic [WORK_W-1:0] quo_src   [STAGES];
    logic [SIDE_W-1:0] side_src  [STAGES];

    function automatic logic [DEN_W+WORK_W-1:0] div_steps(
        input logic [DEN_W-1:0]  r_in,
        input logic [WORK_W-1:0] q_in,
        input logic [DEN_W-1:0]  d
    );
        logic [DEN_W:0]    trial;
        logic [DEN_W-1:0]  r;
        logic [WORK_W-1:0] q;
        r = r_in;
        q = q_in;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            trial = {r, q[WORK_W-1]};
            q     = {q[WORK_W-2:0], 1'b0};
            if (trial >= {1'b0, d})
            begin
                trial = trial - {1'b0, d};
                q[0]  = 1'b1;
            end
            r = trial[DEN_W-1:0];
        end
        return {r, q};
    endfunction

    assign en[STAGES] = out_ready;
    assign in_ready   = en[0];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic [DEN_W+WORK_W-1:0] step_next;

        if (i == 0)
        begin : g_head
            assign valid_src[i] = in_valid;
            assign rem_src[i]   = '0;
            assign quo_src[i]   = WORK_W'(num);
            assign side_src[i]  = side_in;
        end
        else
        begin : g_body
            assign valid_src[i] = valid_reg[i-1];
            assign rem_src[i]   = rem_reg[i-1];
            assign quo_src[i]   = quo_reg[i-1];
            assign side_src[i]  = side_reg[i-1];
        end

        assign en[i] = !valid_reg[i] || en[i+1];

        always_comb
        begin
            step_next = div_steps(rem_src[i], quo_src[i], den);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en[i])
            begin
                valid_reg[i] <= valid_src[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                rem_reg[i]  <= step_next[DEN_W+WORK_W-1 -: DEN_W];
                quo_reg[i]  <= step_next[WORK_W-1:0];
                side_reg[i] <= side_src[i];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quo       = NUM_W'(quo_reg[STAGES-1]);
    assign rem       = rem_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

[design/lrfg_phase.sv]
// Two-stage segment decoder: classifies the position within the period and forms
// the ramp numerator offset times full scale. Depends on lrfg_pkg.
module lrfg_phase #(
    parameter int POS_W = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [POS_W-1:0]              p,
    input  lrfg_pkg::cfg_t                cfg,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lrfg_pkg::NUM_W-1:0]    num,
    output lrfg_pkg::seg_t                seg
);
    import lrfg_pkg::*;

    logic en1, en2;
    logic s1_valid_reg, s2_valid_reg;

    seg_t              s1_seg_reg, s2_seg_reg;
    logic [LEN_W-1:0]  s1_base_reg;
    logic [NUM_W-1:0]  s2_num_reg;

    seg_t              s1_seg_next;
    logic [LEN_W-1:0]  s1_base_next;
    logic [NUM_W-1:0]  s2_num_next;
    logic [PERIOD_W-1:0] p_ext;
    logic [LEN_W-1:0]  fall_start;

    assign en2      = !s2_valid_reg || out_ready;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        p_ext      = PERIOD_W'(p);
        fall_start = (cfg.ramp_length > cfg.on_length) ? cfg.ramp_length : cfg.on_length;
        if (p_ext < PERIOD_W'(cfg.ramp_length))
        begin
            s1_seg_next = SEG_RISE;
        end
        else if (p_ext < PERIOD_W'(cfg.on_length))
        begin
            s1_seg_next = SEG_TOP;
        end
        else if (p_ext < PERIOD_W'(cfg.on_length) + PERIOD_W'(cfg.ramp_length))
        begin
            s1_seg_next = SEG_FALL;
        end
        else
        begin
            s1_seg_next = SEG_DARK;
        end
        if (s1_seg_next == SEG_RISE)
        begin
            s1_base_next = LEN_W'(p_ext);
        end
        else
        begin
            s1_base_next = LEN_W'(p_ext - PERIOD_W'(fall_start));
        end
    end

    assign s2_num_next = s1_base_reg * cfg.full_scale;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_seg_reg  <= s1_seg_next;
            s1_base_reg <= s1_base_next;
        end
        if (en2)
        begin
            s2_seg_reg <= s1_seg_reg;
            s2_num_reg <= s2_num_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign num       = s2_num_reg;
    assign seg       = s2_seg_reg;

endmodule

[design/lrfg_pct_scale.sv]
// Three-stage percent scaler: multiplies the level by the intensity and divides by 100
// through a reciprocal multiply with one correction step. Depends on lrfg_pkg.
module lrfg_pct_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lrfg_pkg::DUTY_W-1:0]   level,
    input  logic [lrfg_pkg::PCT_W-1:0]    pct,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lrfg_pkg::DUTY_W-1:0]   duty
);
    import lrfg_pkg::*;

    localparam int PROD_W = SCALED_W + DIV100_RECIP_W;

    logic en1, en2, en3;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    logic [SCALED_W-1:0]       s1_val_reg, s2_val_reg;
    logic [DIV100_RECIP_W-1:0] s2_quo_reg;
    logic [DUTY_W-1:0]         s3_duty_reg;

    logic [SCALED_W-1:0]       s1_val_next;
    logic [PROD_W-1:0]         recip_prod;
    logic [SCALED_W-1:0]       rest;
    logic [DUTY_W-1:0]         s3_duty_next;

    assign en3      = !s3_valid_reg || out_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    assign s1_val_next = level * pct;
    assign recip_prod  = s1_val_reg * DIV100_RECIP;

    always_comb
    begin
        rest         = s2_val_reg - SCALED_W'(s2_quo_reg * PCT_MAX);
        s3_duty_next = DUTY_W'(s2_quo_reg);
        if (rest >= SCALED_W'(PCT_MAX))
        begin
            s3_duty_next = DUTY_W'(s2_quo_reg + DIV100_RECIP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_val_reg <= s1_val_next;
        end
        if (en2)
        begin
            s2_val_reg <= s1_val_reg;
            s2_quo_reg <= recip_prod[PROD_W-1 -: DIV100_RECIP_W];
        end
        if (en3)
        begin
            s3_duty_reg <= s3_duty_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign duty      = s3_duty_reg;

endmodule

[design/led_ramped_flash_generator.sv]
// Top level of the LED ramped flash generator: config registers and the duty pipeline.
// Depends on lrfg_pkg, lrfg_if, lrfg_position, lrfg_divider, lrfg_phase and lrfg_pct_scale.
//
// Each beat on samples carries a buffer sample index; each beat on duties carries the
// PWM compare value for that index, in the same order, one result per sample.
// The waveform is a trapezoid: ramp up, flat top, ramp down, dark, scaled by the
// intensity in percent. Registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while no samples are in flight, as the block does
// not enforce this. Writes to unknown indexes are dropped. The pipeline is made of
// three position stages, the period modulo divider at four bits a stage, two
// segment stages, the eight-stage ramp divider and three percent-scaling stages.
// Throughput is one sample per cycle while the receiver does not stall. Every stage
// holds a valid bit; when the receiver stalls, the pipeline keeps filling its empty
// stages and then holds, so nothing is dropped or repeated. Reset empties the pipeline
// and loads the register defaults (intensity 100, full scale 32767, lengths and offset 0).
module led_ramped_flash_generator #(
    parameter int BUFFER_SAMPLES = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    lrfg_sample_if.sink                      samples,
    lrfg_duty_if.source                      duties,
    input  logic                             cfg_we,
    input  logic [lrfg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lrfg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import lrfg_pkg::*;

    localparam int POS_W = $clog2(BUFFER_SAMPLES);

    cfg_t cfg_reg, cfg_next;

    logic [PERIOD_W-1:0] period;
    logic [PCT_W-1:0]    pct_sat;

    logic                pos_valid, pos_ready;
    logic [POS_W-1:0]    pos;
    logic                rem_valid, rem_ready;
    logic [PERIOD_W-1:0] remainder;
    logic                num_valid, num_ready;
    logic [NUM_W-1:0]    numerator;
    seg_t                num_seg;
    logic                quo_valid, quo_ready;
    logic [NUM_W-1:0]    quotient;
    seg_t                quo_seg;
    logic [DUTY_W-1:0]   level;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ON_LENGTH:   cfg_next.on_length      = LEN_W'(cfg_wdata);
                REG_OFF_LENGTH:  cfg_next.off_length     = LEN_W'(cfg_wdata);
                REG_RAMP_LENGTH: cfg_next.ramp_length    = LEN_W'(cfg_wdata);
                REG_INTENSITY:   cfg_next.brightness_pct = PCT_W'(cfg_wdata);
                REG_OFFSET:      cfg_next.phase_offset   = OFS_W'(cfg_wdata);
                REG_FULL_SCALE:  cfg_next.full_scale     = DUTY_W'(cfg_wdata);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_length      <= '0;
            cfg_reg.off_length     <= '0;
            cfg_reg.ramp_length    <= '0;
            cfg_reg.brightness_pct <= INTENSITY_RESET;
            cfg_reg.phase_offset   <= '0;
            cfg_reg.full_scale     <= FULL_SCALE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        period = PERIOD_W'(cfg_reg.on_length) + PERIOD_W'(cfg_reg.off_length);
        if (PERIOD_W'(cfg_reg.on_length) + PERIOD_W'(cfg_reg.ramp_length) > period)
        begin
            period = PERIOD_W'(cfg_reg.on_length) + PERIOD_W'(cfg_reg.ramp_length);
        end
        pct_sat = cfg_reg.brightness_pct;
        if (cfg_reg.brightness_pct > PCT_W'(PCT_MAX))
        begin
            pct_sat = PCT_W'(PCT_MAX);
        end
    end

    lrfg_position #(
        .BUFFER_SAMPLES (BUFFER_SAMPLES)
    ) u_position (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (samples.valid),
        .in_ready     (samples.ready),
        .sample_index (samples.sample_index),
        .phase_offset (cfg_reg.phase_offset),
        .out_valid    (pos_valid),
        .out_ready    (pos_ready),
        .pos          (pos)
    );

    lrfg_divider #(
        .NUM_W     (POS_W),
        .DEN_W     (PERIOD_W),
        .STEP_BITS (4),
        .SIDE_W    (1)
    ) u_period_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pos_valid),
        .in_ready  (pos_ready),
        .num       (pos),
        .den       (period),
        .side_in   (1'b0),
        .out_valid (rem_valid),
        .out_ready (rem_ready),
        .quo       (),
        .rem       (remainder),
        .side_out  ()
    );

    lrfg_phase #(
        .POS_W (POS_W)
    ) u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rem_valid),
        .in_ready  (rem_ready),
        .p         (POS_W'(remainder)),
        .cfg       (cfg_reg),
        .out_valid (num_valid),
        .out_ready (num_ready),
        .num       (numerator),
        .seg       (num_seg)
    );

    lrfg_divider #(
        .NUM_W     (NUM_W),
        .DEN_W     (LEN_W),
        .STEP_BITS (4),
        .SIDE_W    ($bits(seg_t))
    ) u_ramp_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num_valid),
        .in_ready  (num_ready),
        .num       (numerator),
        .den       (cfg_reg.ramp_length),
        .side_in   (num_seg),
        .out_valid (quo_valid),
        .out_ready (quo_ready),
        .quo       (quotient),
        .rem       (),
        .side_out  (quo_seg)
    );

    always_comb
    begin
        case (quo_seg)
            SEG_RISE: level = quotient[DUTY_W-1:0];
            SEG_TOP:  level = cfg_reg.full_scale;
            SEG_FALL: level = cfg_reg.full_scale - quotient[DUTY_W-1:0];
            default:  level = '0;
        endcase
    end

    lrfg_pct_scale u_pct_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (quo_valid),
        .in_ready  (quo_ready),
        .level     (level),
        .pct       (pct_sat),
        .out_valid (duties.valid),
        .out_ready (duties.ready),
        .duty      (duties.duty)
    );

endmodule

[design/lrfg_checker.sv]
// Port-level checker for the LED ramped flash generator, bound to the top level.
// Depends on lrfg_pkg for the field widths.
module lrfg_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [lrfg_pkg::DUTY_W-1:0]   duty
);
    import lrfg_pkg::*;

    logic [7:0] pending_reg, pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_valid && in_ready && !(out_valid && out_ready))
        begin
            pending_next = pending_reg + 8'd1;
        end
        else if (!(in_valid && in_ready) && out_valid && out_ready)
        begin
            pending_next = pending_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duty))
        else $error("duty beat changed while stalled");

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 8'd0)
        else $error("duty beat without an accepted sample");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("sample channel blocked while the output is free");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("duty beat offered right after reset");

endmodule

bind led_ramped_flash_generator lrfg_checker u_lrfg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (duties.valid),
    .out_ready (duties.ready),
    .duty      (duties.duty)
);
